// ===== sv/ptd_pkg.sv =====
`timescale 1ns / 1ps
package ptd_pkg;

    localparam int HIST_LEN  = 8;
    localparam int IDX_W     = $clog2(HIST_LEN);
    localparam int BEAT_W    = 4;
    localparam int STAMP_W   = 32;
    localparam int SUM_W     = 35;
    localparam int AVG_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // 2 * 30000000, numerator of the rounded tempo division
    localparam logic [SUM_W-1:0] BPM_NUM2 = SUM_W'(60000000);

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd6;

    typedef struct packed {
        logic signed [15:0] high_threshold;
        logic signed [15:0] low_threshold;
        logic [7:0]         decimation;
        logic [7:0]         stable_count;
        logic [19:0]        tolerance_us;
        logic [23:0]        min_interval_us;
        logic [7:0]         repeat_accept;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        high_threshold:  16'sd1024,
        low_threshold:   16'sd102,
        decimation:      8'd50,
        stable_count:    8'd5,
        tolerance_us:    20'd1750,
        min_interval_us: 24'd100000,
        repeat_accept:   8'd4
    };

    typedef struct packed {
        logic              edge_active;
        logic [BEAT_W-1:0] beat_index;
        logic              eval;
        logic              audio;
        logic              start_pulse;
        logic              midi_active;
    } job_t;

endpackage

// ===== sv/ptd_div.sv =====
`timescale 1ns / 1ps
module ptd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ptd_pkg::SUM_W-1:0]   num,
    input  logic [ptd_pkg::SUM_W-1:0]   den,
    output logic                        done,
    output logic [ptd_pkg::SUM_W-1:0]   quo
);
    localparam int CNT_W = $clog2(ptd_pkg::SUM_W + 1);

    logic [ptd_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [ptd_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [ptd_pkg::SUM_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [ptd_pkg::SUM_W:0]   shifted;
    logic [ptd_pkg::SUM_W:0]   trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        shifted   = {rem_reg, quo_reg[ptd_pkg::SUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(ptd_pkg::SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[ptd_pkg::SUM_W]) begin
                rem_next = trial[ptd_pkg::SUM_W-1:0];
                quo_next = {quo_reg[ptd_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[ptd_pkg::SUM_W-1:0];
                quo_next = {quo_reg[ptd_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== sv/ptd_queue.sv =====
`timescale 1ns / 1ps
module ptd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ptd_pkg::job_t       push_job,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output ptd_pkg::job_t       head
);
    ptd_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];
endmodule

// ===== sv/ptd_front.sv =====
`timescale 1ns / 1ps
module ptd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptd_pkg::cfg_t                 cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic signed [15:0]            s_sample,
    input  logic [ptd_pkg::STAMP_W-1:0]   s_timestamp_us,
    input  logic                          lock_flag,
    input  logic                          eval_done,
    input  logic                          q_full,
    output logic                          q_push,
    output ptd_pkg::job_t                 q_job,
    input  logic [ptd_pkg::IDX_W-1:0]     rd_idx,
    output logic [ptd_pkg::STAMP_W-1:0]   rd_stamp
);
    logic [ptd_pkg::STAMP_W-1:0] stamps_reg [ptd_pkg::HIST_LEN];
    logic [ptd_pkg::STAMP_W-1:0] last_reg, last_next;
    logic [7:0]  phase_reg, phase_next;
    logic [7:0]  high_run_reg, high_run_next;
    logic [7:0]  low_run_reg, low_run_next;
    logic        edge_reg, edge_next;
    logic [ptd_pkg::BEAT_W-1:0] beat_reg, beat_next;
    logic        midi_reg, midi_next;
    logic        wait_reg, wait_next;
    logic        accept, stamp_we, eval, pulse, advance, is_hi, is_lo, too_soon;
    logic [ptd_pkg::IDX_W-1:0]  k;
    logic [ptd_pkg::BEAT_W-1:0] beat_plus;
    logic [8:0]  dec9, phase_plus;
    logic [ptd_pkg::STAMP_W-1:0] gap;

    assign s_ready = !wait_reg && !q_full;
    assign accept  = s_valid && s_ready;
    assign k       = beat_reg[ptd_pkg::IDX_W-1:0];
    assign beat_plus = {1'b0, k} + 1'b1;
    assign gap     = s_timestamp_us - last_reg;
    assign too_soon = (k != '0) && (gap < {8'd0, cfg.min_interval_us});
    assign is_hi   = s_sample > cfg.high_threshold;
    assign is_lo   = s_sample < cfg.low_threshold;
    assign dec9    = (cfg.decimation == 8'd0) ? 9'd1 : {1'b0, cfg.decimation};
    assign phase_plus = {1'b0, phase_reg} + 9'd1;

    always_comb begin
        phase_next    = phase_reg;
        high_run_next = high_run_reg;
        low_run_next  = low_run_reg;
        edge_next     = edge_reg;
        beat_next     = beat_reg;
        midi_next     = midi_reg;
        last_next     = last_reg;
        wait_next     = wait_reg;
        stamp_we      = 1'b0;
        eval          = 1'b0;
        pulse         = 1'b0;
        advance       = 1'b0;
        if (eval_done) wait_next = 1'b0;
        if (accept) begin
            if (s_mode) begin
                midi_next = 1'b1;
                if (lock_flag) begin
                    pulse = 1'b1;
                end else begin
                    stamp_we  = 1'b1;
                    last_next = s_timestamp_us;
                    beat_next = beat_plus;
                    if (beat_plus == ptd_pkg::BEAT_W'(ptd_pkg::HIST_LEN)) begin
                        eval      = 1'b1;
                        beat_next = '0;
                    end
                end
            end else if (!midi_reg) begin
                advance = 1'b1;
                if (phase_reg == 8'd0) begin
                    if (is_hi) begin
                        high_run_next = (high_run_reg == 8'hFF) ? 8'hFF : high_run_reg + 8'd1;
                        low_run_next  = '0;
                    end else if (is_lo) begin
                        low_run_next  = (low_run_reg == 8'hFF) ? 8'hFF : low_run_reg + 8'd1;
                        high_run_next = '0;
                    end else begin
                        advance = 1'b0;
                    end
                    if (advance && !edge_reg && cfg.stable_count != 8'd0
                        && high_run_next == cfg.stable_count) begin
                        edge_next = 1'b1;
                        if (lock_flag) begin
                            pulse = 1'b1;
                        end else begin
                            stamp_we  = 1'b1;
                            last_next = s_timestamp_us;
                            if (too_soon) begin
                                beat_next = '0;
                            end else if (beat_plus == ptd_pkg::BEAT_W'(ptd_pkg::HIST_LEN)) begin
                                eval      = 1'b1;
                                beat_next = '0;
                            end else begin
                                beat_next = beat_plus;
                            end
                        end
                    end else if (advance && edge_reg && cfg.stable_count != 8'd0
                                 && low_run_next == cfg.stable_count) begin
                        edge_next = 1'b0;
                    end
                end
                if (advance)
                    phase_next = (phase_plus >= dec9) ? 8'd0 : phase_plus[7:0];
            end
            if (eval) wait_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            high_run_reg <= '0;
            low_run_reg  <= '0;
            edge_reg     <= 1'b0;
            beat_reg     <= '0;
            midi_reg     <= 1'b0;
            wait_reg     <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            high_run_reg <= high_run_next;
            low_run_reg  <= low_run_next;
            edge_reg     <= edge_next;
            beat_reg     <= beat_next;
            midi_reg     <= midi_next;
            wait_reg     <= wait_next;
        end
        last_reg <= last_next;
        if (stamp_we) stamps_reg[k] <= s_timestamp_us;
    end

    assign rd_stamp = stamps_reg[rd_idx];
    assign q_push   = accept;
    always_comb begin
        q_job.edge_active = edge_next;
        q_job.beat_index  = beat_next;
        q_job.eval        = eval;
        q_job.audio       = !s_mode;
        q_job.start_pulse = pulse;
        q_job.midi_active = midi_next;
    end
endmodule

// ===== sv/ptd_back.sv =====
`timescale 1ns / 1ps
module ptd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptd_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  ptd_pkg::job_t                 q_head,
    output logic                          q_pop,
    output logic [ptd_pkg::IDX_W-1:0]     rd_idx,
    input  logic [ptd_pkg::STAMP_W-1:0]   rd_stamp,
    output logic                          lock_flag,
    output logic                          eval_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_edge_active,
    output logic [3:0]                    m_beat_index,
    output logic                          m_tempo_found,
    output logic [15:0]                   m_bpm,
    output logic                          m_locked,
    output logic                          m_start_pulse,
    output logic                          m_midi_active
);
    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_AVG_GO, S_AVG_W, S_CHK, S_BPM_GO, S_BPM_W, S_FIN
    } state_t;

    state_t state_reg, state_next;
    ptd_pkg::job_t job_reg, job_next;
    logic [ptd_pkg::IDX_W:0]     j_reg, j_next;
    logic [ptd_pkg::STAMP_W-1:0] prev_reg, prev_next;
    logic [ptd_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [ptd_pkg::AVG_W-1:0]   avg_reg, avg_next;
    logic        ok_reg, ok_next;
    logic [15:0] bpm_reg, bpm_next;
    logic [15:0] rep_bpm_reg, rep_bpm_next;
    logic [7:0]  rep_runs_reg, rep_runs_next, runs_inc;
    logic [15:0] tempo_reg, tempo_next;
    logic        lock_reg, lock_next;
    logic        done_reg, done_next;
    logic        mv_reg, mv_next;
    logic        me_reg, me_next, mf_reg, mf_next, mp_reg, mp_next, mm_reg, mm_next;
    logic        ml_reg, ml_next;
    logic [3:0]  mb_reg, mb_next;
    logic [15:0] mbpm_reg, mbpm_next;
    logic        out_free, div_start, div_done, good;
    logic [ptd_pkg::SUM_W-1:0]   div_num, div_den, div_quo;
    logic [ptd_pkg::STAMP_W-1:0] d;
    logic [ptd_pkg::AVG_W-1:0]   dev;
    logic [ptd_pkg::SUM_W-4:0]   eighth;
    logic        last_j;

    ptd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
    );

    assign out_free = !mv_reg || m_ready;
    assign rd_idx   = j_reg[ptd_pkg::IDX_W-1:0];
    assign d        = rd_stamp - prev_reg;
    assign dev      = (avg_reg > {1'b0, d}) ? avg_reg - {1'b0, d} : {1'b0, d} - avg_reg;
    assign last_j   = j_reg == (ptd_pkg::IDX_W + 1)'(ptd_pkg::HIST_LEN - 1);
    assign runs_inc = (rep_runs_reg == 8'hFF) ? 8'hFF : rep_runs_reg + 8'd1;
    assign eighth   = sum_reg[ptd_pkg::SUM_W-1:3];
    assign div_start = (state_reg == S_BPM_GO) && (avg_reg != '0);
    assign div_num   = ptd_pkg::BPM_NUM2 + {2'b0, avg_reg};
    assign div_den   = {1'b0, avg_reg, 1'b0};

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        j_next        = j_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        avg_next      = avg_reg;
        ok_next       = ok_reg;
        bpm_next      = bpm_reg;
        rep_bpm_next  = rep_bpm_reg;
        rep_runs_next = rep_runs_reg;
        tempo_next    = tempo_reg;
        lock_next     = lock_reg;
        done_next     = 1'b0;
        mv_next       = mv_reg && !m_ready;
        me_next = me_reg; mb_next = mb_reg; mf_next = mf_reg; mbpm_next = mbpm_reg;
        ml_next = ml_reg; mp_next = mp_reg; mm_next = mm_reg;
        q_pop         = 1'b0;
        good          = ok_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    if (q_head.eval) begin
                        state_next = S_SUM;
                        j_next     = '0;
                        sum_next   = '0;
                    end else begin
                        mv_next   = 1'b1;
                        me_next   = q_head.edge_active;
                        mb_next   = q_head.beat_index;
                        mf_next   = 1'b0;
                        mbpm_next = tempo_reg;
                        ml_next   = lock_reg;
                        mp_next   = q_head.start_pulse;
                        mm_next   = q_head.midi_active;
                    end
                end
            end
            S_SUM: begin
                if (j_reg != '0) sum_next = sum_reg + {3'b0, d};
                prev_next = rd_stamp;
                if (last_j) state_next = S_AVG_GO;
                else j_next = j_reg + 1'b1;
            end
            S_AVG_GO: begin
                avg_next   = '0;
                state_next = S_AVG_W;
            end
            // divide by seven: since 8 = 7 + 1, move sum/8 into the quotient and
            // fold it back into the remainder until fewer than eight are left
            S_AVG_W: begin
                if (eighth != '0) begin
                    avg_next = avg_reg + {1'b0, eighth};
                    sum_next = {3'b0, eighth} + {{(ptd_pkg::SUM_W-3){1'b0}}, sum_reg[2:0]};
                end else begin
                    if (sum_reg[2:0] == 3'd7) avg_next = avg_reg + 1'b1;
                    j_next     = '0;
                    ok_next    = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (j_reg != '0) begin
                    if (dev > {13'd0, cfg.tolerance_us}) ok_next = 1'b0;
                    if (job_reg.audio && d < {8'd0, cfg.min_interval_us}) ok_next = 1'b0;
                end
                prev_next = rd_stamp;
                if (last_j) state_next = S_BPM_GO;
                else j_next = j_reg + 1'b1;
            end
            S_BPM_GO: begin
                if (avg_reg == '0) begin
                    bpm_next   = 16'hFFFF;
                    state_next = S_FIN;
                end else begin
                    state_next = S_BPM_W;
                end
            end
            S_BPM_W: begin
                if (div_done) begin
                    bpm_next   = (|div_quo[ptd_pkg::SUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (job_reg.audio && !ok_reg) begin
                        if (bpm_reg == rep_bpm_reg) begin
                            rep_runs_next = runs_inc;
                            if (runs_inc == cfg.repeat_accept) good = 1'b1;
                        end else begin
                            rep_bpm_next  = bpm_reg;
                            rep_runs_next = '0;
                        end
                    end
                    if (good) begin
                        tempo_next = bpm_reg;
                        lock_next  = 1'b1;
                    end
                    mv_next    = 1'b1;
                    me_next    = job_reg.edge_active;
                    mb_next    = job_reg.beat_index;
                    mf_next    = good;
                    mbpm_next  = good ? bpm_reg : tempo_reg;
                    ml_next    = good || lock_reg;
                    mp_next    = job_reg.start_pulse;
                    mm_next    = job_reg.midi_active;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rep_bpm_reg  <= '0;
            rep_runs_reg <= '0;
            tempo_reg    <= '0;
            lock_reg     <= 1'b0;
            done_reg     <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rep_bpm_reg  <= rep_bpm_next;
            rep_runs_reg <= rep_runs_next;
            tempo_reg    <= tempo_next;
            lock_reg     <= lock_next;
            done_reg     <= done_next;
            mv_reg       <= mv_next;
        end
        job_reg  <= job_next;
        j_reg    <= j_next;
        prev_reg <= prev_next;
        sum_reg  <= sum_next;
        avg_reg  <= avg_next;
        ok_reg   <= ok_next;
        bpm_reg  <= bpm_next;
        me_reg   <= me_next;
        mb_reg   <= mb_next;
        mf_reg   <= mf_next;
        mbpm_reg <= mbpm_next;
        ml_reg   <= ml_next;
        mp_reg   <= mp_next;
        mm_reg   <= mm_next;
    end

    assign lock_flag     = lock_reg;
    assign eval_done     = done_reg;
    assign m_valid       = mv_reg;
    assign m_edge_active = me_reg;
    assign m_beat_index  = mb_reg;
    assign m_tempo_found = mf_reg;
    assign m_bpm         = mbpm_reg;
    assign m_locked      = ml_reg;
    assign m_start_pulse = mp_reg;
    assign m_midi_active = mm_reg;
endmodule

// ===== sv/pulse_tempo_detector_top.sv =====
`timescale 1ns / 1ps
// a request that closes no run passes the front, the job queue and the result register
// a request that completes eight stamps is evaluated in steps: two 8-step stamp sweeps,
// a shift-and-add division by seven and a pass of the bit-serial divider for the tempo
// throughput: one request a cycle unless the job queue is full; intake stops during evaluation
// reset: aresetn synchronous active low; clears control state and loads register defaults
module pulse_tempo_detector_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptd_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [15:0]                s_sample,
    input  logic [31:0]                       s_timestamp_us,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_edge_active,
    output logic [3:0]                        m_beat_index,
    output logic                              m_tempo_found,
    output logic [15:0]                       m_bpm,
    output logic                              m_locked,
    output logic                              m_start_pulse,
    output logic                              m_midi_active
);
    ptd_pkg::cfg_t cfg_reg;
    ptd_pkg::job_t push_job, head_job;
    logic push, pop, q_full, q_valid, lock_flag, eval_done;
    logic [ptd_pkg::IDX_W-1:0]   rd_idx;
    logic [ptd_pkg::STAMP_W-1:0] rd_stamp;

    // register file, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ptd_pkg::CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ptd_pkg::REG_HIGH_TH: cfg_reg.high_threshold  <= cfg_wdata[15:0];
                ptd_pkg::REG_LOW_TH:  cfg_reg.low_threshold   <= cfg_wdata[15:0];
                ptd_pkg::REG_DECIM:   cfg_reg.decimation      <= cfg_wdata[7:0];
                ptd_pkg::REG_STABLE:  cfg_reg.stable_count    <= cfg_wdata[7:0];
                ptd_pkg::REG_TOL:     cfg_reg.tolerance_us    <= cfg_wdata[19:0];
                ptd_pkg::REG_MIN_INT: cfg_reg.min_interval_us <= cfg_wdata[23:0];
                ptd_pkg::REG_REPEAT:  cfg_reg.repeat_accept   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // front: decimation, threshold runs, edge detection and stamp history
    ptd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_sample(s_sample), .s_timestamp_us(s_timestamp_us),
        .lock_flag(lock_flag), .eval_done(eval_done),
        .q_full(q_full), .q_push(push), .q_job(push_job),
        .rd_idx(rd_idx), .rd_stamp(rd_stamp)
    );

    // two-entry job queue decouples front and back
    ptd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_job(push_job),
        .pop(pop), .full(q_full), .not_empty(q_valid), .head(head_job)
    );

    // back: run evaluation, tempo lock and the result register
    ptd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_head(head_job), .q_pop(pop),
        .rd_idx(rd_idx), .rd_stamp(rd_stamp),
        .lock_flag(lock_flag), .eval_done(eval_done),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_edge_active(m_edge_active), .m_beat_index(m_beat_index),
        .m_tempo_found(m_tempo_found), .m_bpm(m_bpm), .m_locked(m_locked),
        .m_start_pulse(m_start_pulse), .m_midi_active(m_midi_active)
    );
endmodule
